/* design/graph_pinnacle_set_check_core_defines.svh */
// Assertion macros used by the pinnacle set check merge stage.
`ifndef GRAPH_PINNACLE_SET_CHECK_CORE_DEFINES_SVH
`define GRAPH_PINNACLE_SET_CHECK_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GPSC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gpsc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define GPSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gpsc assertion failed");

`endif

/* design/gpsc_pkg.sv */
// Shared constants and types for the pinnacle set check.
`default_nettype none
package gpsc_pkg;

   localparam int VERTICES   = 8;
   localparam int LABEL_BITS = 4;
   localparam int ROW_STRIDE = 8;
   localparam int COUNT_BITS = 4;
   localparam int ADDR_BITS  = 4;
   localparam int DATA_BITS  = 64;
   localparam int ADJ_BITS   = 64;
   localparam int MASK_BITS  = 1 << LABEL_BITS;

   // Register select is the 8-byte word address bit
   localparam logic REG_ADJACENCY    = 1'b0;
   localparam logic REG_VERTEX_COUNT = 1'b1;

   localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(VERTICES);

   typedef logic [LABEL_BITS-1:0] label_type;
   typedef label_type [VERTICES-1:0] label_array_type;
   typedef logic [VERTICES-1:0] vertex_vec_type;

   // Lane stage status handed to the merge stage
   typedef struct packed {
      logic           valid;
      vertex_vec_type mismatch;
   } stage_type;

endpackage
`default_nettype wire

/* design/gpsc_lane.sv */
// One vertex lane: decides whether its vertex acts as a pinnacle and flags a mask mismatch.
`default_nettype none
module gpsc_lane (
   input  wire                              clock,
   input  wire                              lane_active,
   input  wire gpsc_pkg::label_type         own_label,
   input  wire gpsc_pkg::vertex_vec_type    neighbor_row,
   input  wire gpsc_pkg::label_array_type   labels,
   input  wire [gpsc_pkg::MASK_BITS-1:0]    claim_mask,
   output logic                             mismatch_ff
);

   logic                           mismatch_in;
   logic                           has_neighbor;
   gpsc_pkg::vertex_vec_type       beats;
   logic                           pinnacle;
   logic                           claimed;

   // Strictly above every active neighbor; rows already masked to active vertices
   always_comb begin
      for (int n = 0; n < gpsc_pkg::VERTICES; n++) begin
         beats[n] = !neighbor_row[n] || (own_label > labels[n]);
      end
   end

   assign has_neighbor = |neighbor_row;
   assign pinnacle     = has_neighbor && (&beats);
   assign claimed      = claim_mask[own_label];
   assign mismatch_in  = lane_active && (pinnacle != claimed);

   // Lane result register
   always_ff @(posedge clock) begin
      mismatch_ff <= mismatch_in;
   end

endmodule
`default_nettype wire

/* design/gpsc_merge.sv */
// Merge stage: combines lane mismatch flags into the registered result word.
`default_nettype none
`include "graph_pinnacle_set_check_core_defines.svh"
module gpsc_merge (
   input  wire                   clock,
   input  wire                   reset,
   input  wire gpsc_pkg::stage_type stage,
   output logic                  rsp_valid,
   output logic                  rsp_valid_res
);

   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic rsp_valid_res_ff;
   logic rsp_valid_res_in;

   assign rsp_valid_in     = stage.valid;
   assign rsp_valid_res_in = ~|stage.mismatch;

   // Result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_valid_res_ff <= rsp_valid_res_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_valid_res_ff;

   // Every lane word yields exactly one result, in the following cycle
   `GPSC_ASSERT_NEXT(a_strobe_follows, clock, reset, stage.valid, rsp_valid)
   `GPSC_ASSERT_NEXT(a_no_spurious, clock, reset, !stage.valid, !rsp_valid)
   `GPSC_ASSERT_NEXT(a_result_value, clock, reset, stage.valid,
      rsp_valid_res == ~|$past(stage.mismatch))

endmodule
`default_nettype wire

/* design/graph_pinnacle_set_check_core.sv */
// Pinnacle set check core: one candidate labeling per cycle, eight vertex lanes and a merge stage.
// A word is accepted on every cycle with start high (busy is always low). Each word yields
// one result on rsp_valid_res, strobed by rsp_valid once it has passed the lane and
// merge registers; results come in order and cannot be stalled. The rate is one word per cycle,
// with the eight lanes each comparing a vertex label against all neighbors combinationally.
// Configure adjacency (address 0) and vertex_count (address 8) only while no word is in flight.
`default_nettype none
module graph_pinnacle_set_check_core (
   input  wire                                  clock,
   input  wire                                  reset,
   // command channel
   input  wire                                  start,
   output logic                                 busy,
   input  wire [31:0]                           req_vertex_labels,
   input  wire [15:0]                           req_pinnacle_mask,
   // result channel
   output logic                                 rsp_valid,
   output logic                                 rsp_valid_res,
   // register port
   input  wire                                  psel,
   input  wire                                  penable,
   input  wire                                  pwrite,
   input  wire [gpsc_pkg::ADDR_BITS-1:0]        paddr,
   input  wire [gpsc_pkg::DATA_BITS-1:0]        pwdata,
   output logic [gpsc_pkg::DATA_BITS-1:0]       prdata,
   output logic                                 pready
);

   logic [gpsc_pkg::ADJ_BITS-1:0]   adjacency_ff;
   logic [gpsc_pkg::ADJ_BITS-1:0]   adjacency_in;
   logic [gpsc_pkg::COUNT_BITS-1:0] vertex_count_ff;
   logic [gpsc_pkg::COUNT_BITS-1:0] vertex_count_in;
   logic                            csr_write;
   logic                            accept;
   logic                            stage_valid_ff;
   logic                            stage_valid_in;
   logic [gpsc_pkg::COUNT_BITS-1:0] count_sat;
   gpsc_pkg::vertex_vec_type        active;
   gpsc_pkg::vertex_vec_type        lane_mismatch;
   gpsc_pkg::label_array_type       labels;
   gpsc_pkg::stage_type             stage;

   assign busy   = 1'b0;
   assign pready = 1'b1;
   assign accept = start && !busy;

   // Register writes
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      adjacency_in    = adjacency_ff;
      vertex_count_in = vertex_count_ff;
      if (csr_write) begin
         unique case (paddr[3])
            gpsc_pkg::REG_ADJACENCY: begin
               adjacency_in = pwdata[gpsc_pkg::ADJ_BITS-1:0];
            end
            gpsc_pkg::REG_VERTEX_COUNT: begin
               vertex_count_in = pwdata[gpsc_pkg::COUNT_BITS-1:0];
            end
            default: begin
               adjacency_in = adjacency_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         adjacency_ff    <= '0;
         vertex_count_ff <= gpsc_pkg::COUNT_RESET;
      end else begin
         adjacency_ff    <= adjacency_in;
         vertex_count_ff <= vertex_count_in;
      end
   end

   // Register reads
   always_comb begin
      unique case (paddr[3])
         gpsc_pkg::REG_ADJACENCY:    prdata = adjacency_ff;
         gpsc_pkg::REG_VERTEX_COUNT: prdata = gpsc_pkg::DATA_BITS'(vertex_count_ff);
         default:                    prdata = '0;
      endcase
   end

   // Active vertex set, count saturated to the lane count
   assign count_sat = (vertex_count_ff > gpsc_pkg::COUNT_BITS'(gpsc_pkg::VERTICES)) ?
                      gpsc_pkg::COUNT_BITS'(gpsc_pkg::VERTICES) : vertex_count_ff;

   always_comb begin
      for (int v = 0; v < gpsc_pkg::VERTICES; v++) begin
         active[v] = gpsc_pkg::COUNT_BITS'(v) < count_sat;
      end
   end

   assign labels = req_vertex_labels[gpsc_pkg::VERTICES*gpsc_pkg::LABEL_BITS-1:0];

   // Vertex lanes
   for (genvar v = 0; v < gpsc_pkg::VERTICES; v++) begin : g_lane
      gpsc_lane u_lane (
         .clock        (clock),
         .lane_active  (active[v]),
         .own_label    (labels[v]),
         .neighbor_row (adjacency_ff[v*gpsc_pkg::ROW_STRIDE +: gpsc_pkg::VERTICES] & active),
         .labels       (labels),
         .claim_mask   (req_pinnacle_mask[gpsc_pkg::MASK_BITS-1:0]),
         .mismatch_ff  (lane_mismatch[v])
      );
   end

   // Lane stage valid
   assign stage_valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   assign stage.valid    = stage_valid_ff;
   assign stage.mismatch = lane_mismatch;

   // Merge and result register
   gpsc_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .stage         (stage),
      .rsp_valid     (rsp_valid),
      .rsp_valid_res (rsp_valid_res)
   );

endmodule
`default_nettype wire
